// ----- sv/assert_macros.svh -----
// Assertion macros for the checker file of the stepper.
// Needs nothing else; each macro builds one clocked property with reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SIS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stepper assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stepper assertion failed");

`endif

// ----- sv/sis_pkg.sv -----
// Package of the segment interpolation stepper: request and response types,
// operation and field codes, table row layout and parameter defaults. No dependencies.
package sis_pkg;

    // Field widths of the request and response.
    localparam int VAL_W  = 32;
    localparam int SEG_W  = 10;
    localparam int OP_W   = 2;
    localparam int FSEL_W = 4;
    localparam int LANES  = 4;

    // Parameter defaults.
    localparam int SEGMENTS_DEFAULT   = 1024;
    localparam int POS_FRAC_DEFAULT   = 8;
    localparam int VALUE_FRAC_DEFAULT = 8;

    // The pointer is ten bits wide, so at most this many segments are live.
    localparam int PTR_LIMIT = 1024;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ADVANCE = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE   = 2'd1;
    localparam logic [OP_W-1:0] OP_SEEK    = 2'd2;

    // Field select codes; each value group is ordered left margin, right margin,
    // left depth, right depth.
    localparam logic [FSEL_W-1:0] F_START  = 4'd0;
    localparam logic [FSEL_W-1:0] F_END    = 4'd1;
    localparam logic [FSEL_W-1:0] F_COUNT  = 4'd14;

    // Layout of the row memory, which holds every field but the start sample.
    localparam int ROW_FIELDS = 13;
    localparam int ROW_SEL_W  = 4;
    localparam int R_END  = 0;
    localparam int R_SVAL = 1;
    localparam int R_EVAL = 5;
    localparam int R_STEP = 9;

    typedef logic [LANES-1:0][VAL_W-1:0] acc_t;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic signed [VAL_W-1:0]  delta;
        logic [SEG_W-1:0]         segment_index;
        logic [FSEL_W-1:0]        field_select;
        logic signed [VAL_W-1:0]  field_value;
    } cmd_t;

    typedef struct packed {
        logic signed [VAL_W-1:0]  position;
        logic [SEG_W-1:0]         current_segment;
        logic signed [VAL_W-1:0]  left_margin;
        logic signed [VAL_W-1:0]  right_margin;
        logic signed [VAL_W-1:0]  left_depth;
        logic signed [VAL_W-1:0]  right_depth;
    } rsp_t;

    // Segment fields read from the table for one request.
    typedef struct packed {
        logic signed [VAL_W-1:0]  first_sample;
        logic signed [VAL_W-1:0]  last_sample;
        logic signed [VAL_W-1:0]  next_start;
        acc_t                     start_val;
        acc_t                     end_val;
        acc_t                     step;
    } seg_data_t;

endpackage

// ----- sv/sis_table.sv -----
// Segment table of the stepper: a start-sample memory with two read ports and a
// row memory with per-field writes. Depends on sis_pkg.
module sis_table #(
    parameter int SEGMENTS = sis_pkg::SEGMENTS_DEFAULT,
    localparam int LIVE = (SEGMENTS < sis_pkg::PTR_LIMIT) ? SEGMENTS : sis_pkg::PTR_LIMIT,
    localparam int ADDR_W = $clog2(LIVE)
) (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [ADDR_W-1:0]              wr_addr,
    input  logic [sis_pkg::FSEL_W-1:0]     wr_field,
    input  logic [sis_pkg::VAL_W-1:0]      wr_data,
    input  logic                           rd_en,
    input  logic [ADDR_W-1:0]              rd_addr,
    output sis_pkg::seg_data_t             rd_data
);

    logic [sis_pkg::VAL_W-1:0] start_mem [LIVE];
    logic [sis_pkg::ROW_FIELDS-1:0][sis_pkg::VAL_W-1:0] row_mem [LIVE];

    logic [sis_pkg::VAL_W-1:0] start_q;
    logic [sis_pkg::VAL_W-1:0] next_q;
    logic [sis_pkg::ROW_FIELDS-1:0][sis_pkg::VAL_W-1:0] row_q;

    logic [ADDR_W-1:0]            rd_next_addr;
    logic [sis_pkg::ROW_SEL_W-1:0] row_sel;

    // The neighbor read wraps to zero at the last live segment; its data is unused there.
    assign rd_next_addr = (rd_addr == ADDR_W'(LIVE - 1)) ? '0 : rd_addr + ADDR_W'(1);
    assign row_sel = sis_pkg::ROW_SEL_W'(wr_field - sis_pkg::F_END);

    // Start samples, read at the current segment and at its successor.
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_field == sis_pkg::F_START))
        begin
            start_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            start_q <= start_mem[rd_addr];
            next_q  <= start_mem[rd_next_addr];
        end
    end

    // All other fields of a segment, written one field at a time.
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_field != sis_pkg::F_START))
        begin
            row_mem[wr_addr][row_sel] <= wr_data;
        end
        if (rd_en)
        begin
            row_q <= row_mem[rd_addr];
        end
    end

    // Unpack the registered read data.
    always_comb
    begin
        rd_data.first_sample = start_q;
        rd_data.next_start   = next_q;
        rd_data.last_sample  = row_q[sis_pkg::R_END];
        for (int k = 0; k < sis_pkg::LANES; k++)
        begin
            rd_data.start_val[k] = row_q[sis_pkg::R_SVAL + k];
            rd_data.end_val[k]   = row_q[sis_pkg::R_EVAL + k];
            rd_data.step[k]      = row_q[sis_pkg::R_STEP + k];
        end
    end

endmodule

// ----- sv/sis_step.sv -----
// Update logic of the stepper: from the held state, the request and the segment
// fields read from the table it forms the next position, pointer and accumulators.
// Depends on sis_pkg.
module sis_step #(
    parameter int SEGMENTS               = sis_pkg::SEGMENTS_DEFAULT,
    parameter int POSITION_FRACTION_BITS = sis_pkg::POS_FRAC_DEFAULT,
    parameter int VALUE_FRACTION_BITS    = sis_pkg::VALUE_FRAC_DEFAULT,
    localparam int LIVE = (SEGMENTS < sis_pkg::PTR_LIMIT) ? SEGMENTS : sis_pkg::PTR_LIMIT,
    localparam int ADDR_W = $clog2(LIVE)
) (
    input  logic [sis_pkg::OP_W-1:0]         op,
    input  logic signed [sis_pkg::VAL_W-1:0] delta,
    input  logic [ADDR_W-1:0]                seek_seg,
    input  logic                             tracking,
    input  logic signed [sis_pkg::VAL_W-1:0] pos,
    input  logic [ADDR_W-1:0]                ptr,
    input  sis_pkg::acc_t                    acc,
    input  sis_pkg::seg_data_t               seg,
    output logic signed [sis_pkg::VAL_W-1:0] pos_next,
    output logic [ADDR_W-1:0]                ptr_next,
    output sis_pkg::acc_t                    acc_next
);

    logic signed [sis_pkg::VAL_W-1:0] pos_sum;
    logic signed [sis_pkg::VAL_W-1:0] old_s;
    logic signed [sis_pkg::VAL_W-1:0] new_s;
    logic [ADDR_W:0]                  ptr_inc;
    logic                             has_next;

    // Integer samples before and after the move, and the successor check.
    assign pos_sum  = pos + delta;
    assign old_s    = pos >>> POSITION_FRACTION_BITS;
    assign new_s    = pos_sum >>> POSITION_FRACTION_BITS;
    assign ptr_inc  = {1'b0, ptr} + (ADDR_W + 1)'(1);
    assign has_next = ptr_inc < (ADDR_W + 1)'(LIVE);

    // Decode the operation and apply the segment rules.
    always_comb
    begin
        pos_next = pos;
        ptr_next = ptr;
        acc_next = acc;
        unique case (op)
            sis_pkg::OP_ADVANCE:
            begin
                pos_next = pos_sum;
                if (tracking && (new_s != old_s))
                begin
                    if (delta > 32'sd0)
                    begin
                        // Forward: hop to the next segment, snap to end values, or step.
                        if (new_s > seg.last_sample)
                        begin
                            if (has_next && (new_s == seg.next_start))
                            begin
                                ptr_next = ptr_inc[ADDR_W-1:0];
                            end
                        end
                        else if (new_s == seg.last_sample)
                        begin
                            for (int k = 0; k < sis_pkg::LANES; k++)
                            begin
                                acc_next[k] = seg.end_val[k] << VALUE_FRACTION_BITS;
                            end
                        end
                        else
                        begin
                            for (int k = 0; k < sis_pkg::LANES; k++)
                            begin
                                acc_next[k] = acc[k] + seg.step[k];
                            end
                        end
                    end
                    else if (delta < 32'sd0)
                    begin
                        // Backward: nothing at or past the end sample.
                        if (new_s < seg.last_sample)
                        begin
                            if (new_s > seg.first_sample)
                            begin
                                for (int k = 0; k < sis_pkg::LANES; k++)
                                begin
                                    acc_next[k] = acc[k] - seg.step[k];
                                end
                            end
                            else if (new_s != seg.first_sample)
                            begin
                                if (ptr != '0)
                                begin
                                    ptr_next = ptr - ADDR_W'(1);
                                end
                            end
                            else
                            begin
                                for (int k = 0; k < sis_pkg::LANES; k++)
                                begin
                                    acc_next[k] = seg.start_val[k] << VALUE_FRACTION_BITS;
                                end
                            end
                        end
                    end
                end
            end
            sis_pkg::OP_SEEK:
            begin
                pos_next = delta;
                ptr_next = seek_seg;
                for (int k = 0; k < sis_pkg::LANES; k++)
                begin
                    acc_next[k] = seg.start_val[k] << VALUE_FRACTION_BITS;
                end
            end
            default:
            begin
                // Table writes and the unused code leave the state alone.
                pos_next = pos;
            end
        endcase
    end

endmodule

// ----- sv/segment_interpolation_stepper.sv -----
// Segment interpolation stepper, top level: request staging, state registers,
// response register. Depends on sis_pkg, sis_table and sis_step.
// A request accepted at a clock edge has its table read and staged fields registered; its
// update and response are registered once the response register is free or not stalled.
// The next request is taken only after that update, as its read address needs the pointer.
// Reset clears position, pointer, accumulators, tracking and valids; the table is not cleared.
module segment_interpolation_stepper #(
    parameter int SEGMENTS               = sis_pkg::SEGMENTS_DEFAULT,
    parameter int POSITION_FRACTION_BITS = sis_pkg::POS_FRAC_DEFAULT,
    parameter int VALUE_FRACTION_BITS    = sis_pkg::VALUE_FRAC_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_write_en,
    input  logic            cfg_write_data,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  sis_pkg::cmd_t   cmd,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output sis_pkg::rsp_t   rsp
);

    localparam int LIVE   = (SEGMENTS < sis_pkg::PTR_LIMIT) ? SEGMENTS : sis_pkg::PTR_LIMIT;
    localparam int ADDR_W = $clog2(LIVE);

    logic                              tracking_reg;
    logic                              s1_valid_reg;
    logic                              s1_valid_next;
    logic [sis_pkg::OP_W-1:0]          s1_op_reg;
    logic signed [sis_pkg::VAL_W-1:0]  s1_delta_reg;
    logic [ADDR_W-1:0]                 s1_seek_reg;
    logic signed [sis_pkg::VAL_W-1:0]  pos_reg;
    logic signed [sis_pkg::VAL_W-1:0]  pos_next;
    logic [ADDR_W-1:0]                 ptr_reg;
    logic [ADDR_W-1:0]                 ptr_next;
    sis_pkg::acc_t                     acc_reg;
    sis_pkg::acc_t                     acc_next;
    logic                              rsp_valid_reg;
    logic                              rsp_valid_next;
    sis_pkg::rsp_t                     rsp_reg;

    logic                              accept;
    logic                              complete;
    logic                              seg_in_range;
    logic [ADDR_W-1:0]                 seek_seg;
    logic [ADDR_W-1:0]                 rd_addr;
    logic                              wr_en;
    sis_pkg::seg_data_t                seg_data;

    // One request in flight; the next is taken once the update has been applied.
    assign accept   = cmd_valid && !s1_valid_reg;
    assign complete = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);

    // Seek targets beyond the live segments saturate to the last one.
    assign seg_in_range = {1'b0, cmd.segment_index} < (sis_pkg::SEG_W + 1)'(LIVE);
    assign seek_seg     = seg_in_range ? ADDR_W'(cmd.segment_index) : ADDR_W'(LIVE - 1);
    assign rd_addr      = (cmd.operation == sis_pkg::OP_SEEK) ? seek_seg : ptr_reg;
    assign wr_en        = accept && (cmd.operation == sis_pkg::OP_WRITE) && seg_in_range
                          && (cmd.field_select < sis_pkg::F_COUNT);

    sis_table #(
        .SEGMENTS (SEGMENTS)
    ) u_table (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (ADDR_W'(cmd.segment_index)),
        .wr_field (cmd.field_select),
        .wr_data  (cmd.field_value),
        .rd_en    (accept),
        .rd_addr  (rd_addr),
        .rd_data  (seg_data)
    );

    sis_step #(
        .SEGMENTS               (SEGMENTS),
        .POSITION_FRACTION_BITS (POSITION_FRACTION_BITS),
        .VALUE_FRACTION_BITS    (VALUE_FRACTION_BITS)
    ) u_step (
        .op       (s1_op_reg),
        .delta    (s1_delta_reg),
        .seek_seg (s1_seek_reg),
        .tracking (tracking_reg),
        .pos      (pos_reg),
        .ptr      (ptr_reg),
        .acc      (acc_reg),
        .seg      (seg_data),
        .pos_next (pos_next),
        .ptr_next (ptr_next),
        .acc_next (acc_next)
    );

    // Valid flags of the staged request and the response register.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (complete)
        begin
            s1_valid_next = 1'b0;
        end
        rsp_valid_next = rsp_valid_reg;
        if (complete)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracking_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            pos_reg       <= '0;
            ptr_reg       <= '0;
            acc_reg       <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                tracking_reg <= cfg_write_data;
            end
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (complete)
            begin
                pos_reg <= pos_next;
                ptr_reg <= ptr_next;
                acc_reg <= acc_next;
            end
        end
    end

    // Staged request and response payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= cmd.operation;
            s1_delta_reg <= cmd.delta;
            s1_seek_reg  <= seek_seg;
        end
        if (complete)
        begin
            rsp_reg.position        <= pos_next;
            rsp_reg.current_segment <= sis_pkg::SEG_W'(ptr_next);
            rsp_reg.left_margin     <= acc_next[0];
            rsp_reg.right_margin    <= acc_next[1];
            rsp_reg.left_depth      <= acc_next[2];
            rsp_reg.right_depth     <= acc_next[3];
        end
    end

    assign cmd_stall = s1_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- sv/sis_checker.sv -----
// Port-level checker of the stepper and its bind to the top level.
// Depends on sis_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sis_checker #(
    parameter int SEGMENTS = sis_pkg::SEGMENTS_DEFAULT
) (
    input logic          clk,
    input logic          rst_n,
    input logic          cmd_valid,
    input logic          cmd_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input sis_pkg::rsp_t rsp
);

    localparam int LIVE = (SEGMENTS < sis_pkg::PTR_LIMIT) ? SEGMENTS : sis_pkg::PTR_LIMIT;

    logic cmd_accept;
    logic rsp_hold;
    logic seg_ok;

    assign cmd_accept = cmd_valid && !cmd_stall;
    assign rsp_hold   = rsp_valid && rsp_stall;
    assign seg_ok     = {1'b0, rsp.current_segment} < (sis_pkg::SEG_W + 1)'(LIVE);

    // A request blocks the channel for the cycle of its update.
    `SIS_ASSERT_NEXT(a_stall_after_accept, clk, rst_n, cmd_accept, cmd_stall)
    // A fresh response comes from an accepted request, through the staging and response registers.
    `SIS_ASSERT_NOW(a_rsp_from_request, clk, rst_n, $rose(rsp_valid), $past(cmd_accept, 2))
    // The reported segment is always a live one.
    `SIS_ASSERT_NOW(a_segment_live, clk, rst_n, rsp_valid, seg_ok)
    // A stalled response stays and holds its payload.
    `SIS_ASSERT_NEXT(a_rsp_held, clk, rst_n, rsp_hold, rsp_valid && $stable(rsp))

endmodule

bind segment_interpolation_stepper sis_checker #(.SEGMENTS(SEGMENTS)) u_sis_checker (.*);
